// ===== hw/rtl/gaussian_naive_bayes_two_class_top_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Needs nothing; included by modules that carry checks.
`ifndef GAUSSIAN_NAIVE_BAYES_TWO_CLASS_TOP_MACROS_SVH
`define GAUSSIAN_NAIVE_BAYES_TWO_CLASS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define GNB_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("gnb assertion failed");
// Clocked check, active during reset too
`define GNB_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("gnb assertion failed");
`else
`define GNB_ASSERT(lbl, prop)
`define GNB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/gnb_pkg.sv =====
// Types and constants of the two-class Gaussian naive Bayes classifier.
// No dependencies; used by gnb_mdu, gnb_front, gnb_back and the top level.
package gnb_pkg;

  localparam int DW = 64;

  localparam logic [1:0] CMD_TRAIN = 2'd0;
  localparam logic [1:0] CMD_FINAL = 2'd1;
  localparam logic [1:0] CMD_CLASS = 2'd2;

  localparam logic [1:0] LBL_ONE = 2'd1;
  localparam logic [1:0] LBL_TWO = 2'd2;

  localparam logic       KIND_FINAL = 1'b0;
  localparam logic       KIND_CLASS = 1'b1;

  localparam logic [1:0] PRED_TIE = 2'd0;
  localparam logic [1:0] PRED_ONE = 2'd1;
  localparam logic [1:0] PRED_TWO = 2'd2;

  // log2(e) in Q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef enum logic [1:0] {
    OP_TRAIN,
    OP_FINAL,
    OP_CLASS
  } item_op_t;

  typedef struct packed {
    item_op_t    op;
    logic        cls;
    logic [15:0] h;
    logic [15:0] w;
  } item_t;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_DIV,
    MDU_SQRT
  } mdu_op_t;

  typedef struct packed {
    logic    go;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_MH, S_T_AH, S_T_AW,
    S_F_START, S_F_SSQ, S_F_S2, S_F_VAR, S_F_MEAN, S_F_MW, S_F_DEV, S_F_NEXT,
    S_C_START, S_C_SS, S_C_Z2, S_C_A, S_C_B1, S_C_B2, S_C_E0, S_C_ER, S_C_EM,
    S_C_X, S_C_XM, S_C_XW, S_C_CMP,
    S_EMIT
  } back_state_t;

endpackage

// ===== hw/rtl/gnb_mdu.sv =====
// Shared iterative arithmetic unit: 64-bit multiply, divide and square root.
// Depends on gnb_pkg; one bit (root: one bit pair) per cycle.
module gnb_mdu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gnb_pkg::mdu_req_t         req,
  input  logic [gnb_pkg::DW-1:0]    opa,
  input  logic [gnb_pkg::DW-1:0]    opb,
  output gnb_pkg::mdu_sts_t         sts,
  output logic [gnb_pkg::DW-1:0]    res
);

  gnb_pkg::mdu_op_t       op_r;
  logic [gnb_pkg::DW-1:0] x_r;
  logic [gnb_pkg::DW-1:0] y_r;
  logic [gnb_pkg::DW:0]   acc_r;
  logic [6:0]             cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [gnb_pkg::DW:0]   rem;
  logic [gnb_pkg::DW-1:0] trial;

  assign rem   = {acc_r[gnb_pkg::DW-1:0], x_r[gnb_pkg::DW-1]};
  assign trial = acc_r[gnb_pkg::DW-1:0] + y_r;

  // Iterate one step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        unique case (op_r)
          gnb_pkg::MDU_MUL: begin
            if (y_r[0]) acc_r <= {1'b0, acc_r[gnb_pkg::DW-1:0] + x_r};
            x_r <= {x_r[gnb_pkg::DW-2:0], 1'b0};
            y_r <= {1'b0, y_r[gnb_pkg::DW-1:1]};
          end
          gnb_pkg::MDU_DIV: begin
            if (rem >= {1'b0, y_r}) begin
              acc_r <= rem - {1'b0, y_r};
              x_r   <= {x_r[gnb_pkg::DW-2:0], 1'b1};
            end else begin
              acc_r <= rem;
              x_r   <= {x_r[gnb_pkg::DW-2:0], 1'b0};
            end
          end
          gnb_pkg::MDU_SQRT: begin
            if (x_r >= trial) begin
              x_r   <= x_r - trial;
              acc_r <= {1'b0, (acc_r[gnb_pkg::DW-1:0] >> 1) + y_r};
            end else begin
              acc_r <= {1'b0, acc_r[gnb_pkg::DW-1:0] >> 1};
            end
            y_r <= y_r >> 2;
          end
          default: acc_r <= acc_r;
        endcase
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.go) begin
        op_r   <= req.op;
        x_r    <= opa;
        y_r    <= (req.op == gnb_pkg::MDU_SQRT) ? {2'b01, {(gnb_pkg::DW-2){1'b0}}} : opb;
        acc_r  <= '0;
        cnt_r  <= (req.op == gnb_pkg::MDU_SQRT) ? 7'd32 : 7'd64;
        busy_r <= 1'b1;
      end
    end
  end

  // Quotient lives in x; product and root in acc
  assign res  = (op_r == gnb_pkg::MDU_DIV) ? x_r : acc_r[gnb_pkg::DW-1:0];
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

// ===== hw/rtl/gnb_queue.sv =====
// Small FIFO between the front and back parts of the classifier.
// Depends on gnb_pkg only through the instantiating module.
`include "gaussian_naive_bayes_two_class_top_macros.svh"
module gnb_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [CNW-1:0]   count_r;

  assign full  = (count_r == CNW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= din;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `GNB_ASSERT(a_no_overflow, push |-> !full)
  `GNB_ASSERT(a_no_underflow, pop |-> !empty)
  `GNB_ASSERT(a_count_range, count_r <= CNW'(DEPTH))

endmodule

// ===== hw/rtl/gnb_front.sv =====
// Front part: takes input transactions, decodes the command, drops no-ops.
// Depends on gnb_pkg; feeds gnb_queue.
module gnb_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_command,
  input  logic [1:0]     in_class_label,
  input  logic [15:0]    in_height,
  input  logic [15:0]    in_weight,
  input  logic           q_full,
  output logic           q_push,
  output gnb_pkg::item_t q_item
);

  logic keep;
  gnb_pkg::item_op_t op;

  // Decode command; unknown commands and train items with bad labels carry no work
  always_comb begin
    keep = 1'b0;
    op   = gnb_pkg::OP_TRAIN;
    unique case (in_command)
      gnb_pkg::CMD_TRAIN: begin
        op   = gnb_pkg::OP_TRAIN;
        keep = (in_class_label == gnb_pkg::LBL_ONE) || (in_class_label == gnb_pkg::LBL_TWO);
      end
      gnb_pkg::CMD_FINAL: begin
        op   = gnb_pkg::OP_FINAL;
        keep = 1'b1;
      end
      gnb_pkg::CMD_CLASS: begin
        op   = gnb_pkg::OP_CLASS;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;
  assign q_item   = '{op:  op,
                      cls: (in_class_label == gnb_pkg::LBL_TWO),
                      h:   in_height,
                      w:   in_weight};

endmodule

// ===== hw/rtl/gnb_back.sv =====
// Back part: statistics registers and the sequencer for train, finalize, classify.
// Depends on gnb_pkg and drives the shared gnb_mdu unit.
`include "gaussian_naive_bayes_two_class_top_macros.svh"
module gnb_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gnb_pkg::item_t         q_item,
  input  logic                   q_valid,
  output logic                   q_pop,
  output gnb_pkg::mdu_req_t      mdu_req,
  output logic [gnb_pkg::DW-1:0] mdu_a,
  output logic [gnb_pkg::DW-1:0] mdu_b,
  input  gnb_pkg::mdu_sts_t      mdu_sts,
  input  logic [gnb_pkg::DW-1:0] mdu_res,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic [1:0]             out_predicted_class,
  output logic                   out_error
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 16 + CW;
  localparam int QW = 32 + CW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);
  localparam logic [30:0] LOG2E = gnb_pkg::LOG2E_Q30;

  gnb_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r  [2];
  logic [SW-1:0]  sum_r  [4];
  logic [QW-1:0]  sq_r   [4];
  logic [15:0]    mean_r [4];
  logic [15:0]    dev_r  [4];
  logic           stats_valid_r;

  gnb_pkg::item_t item_r;
  logic [1:0]     idx_r;
  logic           err_r;
  logic [63:0]    prod_r;
  logic [63:0]    tmp_r;
  logic [48:0]    asum_r;
  logic [49:0]    b_r;
  logic [31:0]    root_r;
  logic [31:0]    m_r;
  logic           m_one_r;
  logic [3:0]     bit_r;
  logic [16:0]    mant_r [2];
  logic [33:0]    k_r    [2];
  logic [63:0]    x_r    [2];
  logic           rk_r;
  logic [1:0]     rp_r;
  logic           re_r;

  logic                   go_r, go_nxt;
  gnb_pkg::mdu_op_t       op_r, op_nxt;
  logic [63:0]            ma_r, ma_nxt;
  logic [63:0]            mb_r, mb_nxt;

  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [1:0]             out_pred_r;
  logic                   out_err_r;

  // Datapath helpers
  logic        cc;
  logic [1:0]  tc0, tc1;
  logic [CW-1:0] n_cur;
  logic [15:0] xf, dxf;
  logic [31:0] hh, ww, dd, ss, em_hi;
  logic [63:0] em_prod;
  logic [31:0] dev_x;
  logic [29:0] a_lo;
  logic [17:0] a_hi;
  logic [60:0] lo_prod;
  logic [48:0] hi_prod;
  logic [15:0] frac;
  logic [1:0]  cmp_gl;
  logic        can_emit;

  function automatic logic [1:0] cmp_sh(input logic [63:0] a, input logic [63:0] b,
                                        input logic [33:0] d);
    logic [63:0] q;
    logic        nz;
    logic [5:0]  s;
    s = d[5:0];
    if (d >= 34'd64) begin
      q  = '0;
      nz = |b;
    end else begin
      q  = b >> s;
      nz = |(b & ~({64{1'b1}} << s));
    end
    if (a > q)      return 2'b10;
    else if (a < q) return 2'b01;
    else            return nz ? 2'b01 : 2'b00;
  endfunction

  assign cc      = idx_r[1];
  assign tc0     = {item_r.cls, 1'b0};
  assign tc1     = {item_r.cls, 1'b1};
  assign n_cur   = cnt_r[cc];
  assign hh      = item_r.h * item_r.h;
  assign ww      = item_r.w * item_r.w;
  assign xf      = idx_r[0] ? item_r.w : item_r.h;
  assign dxf     = (xf >= mean_r[idx_r]) ? xf - mean_r[idx_r] : mean_r[idx_r] - xf;
  assign dd      = dxf * dxf;
  assign ss      = dev_r[idx_r] * dev_r[idx_r];
  assign a_lo    = asum_r[30:1];
  assign a_hi    = asum_r[48:31];
  assign lo_prod = a_lo * LOG2E;
  assign hi_prod = a_hi * LOG2E;
  assign frac    = b_r[15:0];
  assign em_prod = m_r * root_r;
  assign em_hi   = em_prod[63:32];
  assign dev_x   = cc ? dev_r[0] * dev_r[1] : dev_r[2] * dev_r[3];
  assign can_emit = !out_valid_r || !out_stall;

  // Compare the two likelihoods: bit 1 class one larger, bit 0 class two larger
  always_comb begin
    logic [1:0] t;
    if (k_r[0] <= k_r[1]) begin
      t = cmp_sh(x_r[0], x_r[1], k_r[1] - k_r[0]);
      cmp_gl = t;
    end else begin
      t = cmp_sh(x_r[1], x_r[0], k_r[0] - k_r[1]);
      cmp_gl = {t[0], t[1]};
    end
  end

  // Next state, queue pop and arithmetic unit issue
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    go_nxt    = 1'b0;
    op_nxt    = op_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    unique case (state_r)
      gnb_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            gnb_pkg::OP_TRAIN:
              state_nxt = (cnt_r[q_item.cls] < MAX_CNT) ? gnb_pkg::S_T_MH : gnb_pkg::S_IDLE;
            gnb_pkg::OP_FINAL: state_nxt = gnb_pkg::S_F_START;
            gnb_pkg::OP_CLASS:
              state_nxt = stats_valid_r ? gnb_pkg::S_C_START : gnb_pkg::S_EMIT;
            default: state_nxt = gnb_pkg::S_IDLE;
          endcase
        end
      end
      gnb_pkg::S_T_MH: state_nxt = gnb_pkg::S_T_AH;
      gnb_pkg::S_T_AH: state_nxt = gnb_pkg::S_T_AW;
      gnb_pkg::S_T_AW: state_nxt = gnb_pkg::S_IDLE;
      gnb_pkg::S_F_START: begin
        if (n_cur == '0) begin
          state_nxt = gnb_pkg::S_F_NEXT;
        end else begin
          go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_MUL;
          ma_nxt = 64'(sum_r[idx_r]); mb_nxt = 64'(sum_r[idx_r]);
          state_nxt = gnb_pkg::S_F_SSQ;
        end
      end
      gnb_pkg::S_F_SSQ: begin
        if (mdu_sts.done) begin
          go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_DIV;
          ma_nxt = mdu_res; mb_nxt = 64'(n_cur);
          state_nxt = gnb_pkg::S_F_S2;
        end
      end
      gnb_pkg::S_F_S2: begin
        if (mdu_sts.done) begin
          if (64'(sq_r[idx_r]) > mdu_res) begin
            go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_DIV;
            ma_nxt = 64'(sq_r[idx_r]) - mdu_res; mb_nxt = 64'(n_cur);
            state_nxt = gnb_pkg::S_F_VAR;
          end else begin
            state_nxt = gnb_pkg::S_F_MEAN;
          end
        end
      end
      gnb_pkg::S_F_VAR: if (mdu_sts.done) state_nxt = gnb_pkg::S_F_MEAN;
      gnb_pkg::S_F_MEAN: begin
        go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_DIV;
        ma_nxt = 64'(sum_r[idx_r]); mb_nxt = 64'(n_cur);
        state_nxt = gnb_pkg::S_F_MW;
      end
      gnb_pkg::S_F_MW: begin
        if (mdu_sts.done) begin
          go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_SQRT;
          ma_nxt = tmp_r; mb_nxt = '0;
          state_nxt = gnb_pkg::S_F_DEV;
        end
      end
      gnb_pkg::S_F_DEV: if (mdu_sts.done) state_nxt = gnb_pkg::S_F_NEXT;
      gnb_pkg::S_F_NEXT:
        state_nxt = (idx_r == 2'd3) ? gnb_pkg::S_EMIT : gnb_pkg::S_F_START;
      gnb_pkg::S_C_START: state_nxt = gnb_pkg::S_C_SS;
      gnb_pkg::S_C_SS: begin
        go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_DIV;
        ma_nxt = {16'd0, prod_r[31:0], 16'd0};
        mb_nxt = (ss == 32'd0) ? 64'd1 : 64'(ss);
        state_nxt = gnb_pkg::S_C_Z2;
      end
      gnb_pkg::S_C_Z2: begin
        if (mdu_sts.done) state_nxt = idx_r[0] ? gnb_pkg::S_C_A : gnb_pkg::S_C_START;
      end
      gnb_pkg::S_C_A:  state_nxt = gnb_pkg::S_C_B1;
      gnb_pkg::S_C_B1: state_nxt = gnb_pkg::S_C_B2;
      gnb_pkg::S_C_B2: state_nxt = gnb_pkg::S_C_E0;
      gnb_pkg::S_C_E0: begin
        go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_SQRT;
        ma_nxt = {32'h8000_0000, 32'd0}; mb_nxt = '0;
        state_nxt = gnb_pkg::S_C_ER;
      end
      gnb_pkg::S_C_ER: if (mdu_sts.done) state_nxt = gnb_pkg::S_C_EM;
      gnb_pkg::S_C_EM: begin
        if (bit_r == 4'd0) begin
          state_nxt = gnb_pkg::S_C_X;
        end else begin
          go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_SQRT;
          ma_nxt = {root_r, 32'd0}; mb_nxt = '0;
          state_nxt = gnb_pkg::S_C_ER;
        end
      end
      gnb_pkg::S_C_X: state_nxt = gnb_pkg::S_C_XM;
      gnb_pkg::S_C_XM: begin
        go_nxt = 1'b1; op_nxt = gnb_pkg::MDU_MUL;
        ma_nxt = 64'(mant_r[cc]); mb_nxt = prod_r;
        state_nxt = gnb_pkg::S_C_XW;
      end
      gnb_pkg::S_C_XW: begin
        if (mdu_sts.done) state_nxt = cc ? gnb_pkg::S_C_CMP : gnb_pkg::S_C_START;
      end
      gnb_pkg::S_C_CMP: state_nxt = gnb_pkg::S_EMIT;
      gnb_pkg::S_EMIT: if (can_emit) state_nxt = gnb_pkg::S_IDLE;
      default: state_nxt = gnb_pkg::S_IDLE;
    endcase
  end

  // State and issue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnb_pkg::S_IDLE;
      go_r    <= 1'b0;
      op_r    <= gnb_pkg::MDU_MUL;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      op_r    <= op_nxt;
    end
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
  end

  // Statistics registers, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 2; j++) cnt_r[j] <= '0;
      for (int j = 0; j < 4; j++) begin
        sum_r[j]  <= '0;
        sq_r[j]   <= '0;
        mean_r[j] <= '0;
        dev_r[j]  <= '0;
      end
      stats_valid_r <= 1'b0;
      err_r         <= 1'b0;
    end else begin
      unique case (state_r)
        gnb_pkg::S_IDLE: err_r <= 1'b0;
        gnb_pkg::S_T_AH: begin
          sum_r[tc0] <= sum_r[tc0] + SW'(item_r.h);
          sq_r[tc0]  <= sq_r[tc0] + QW'(prod_r[31:0]);
        end
        gnb_pkg::S_T_AW: begin
          sum_r[tc1] <= sum_r[tc1] + SW'(item_r.w);
          sq_r[tc1]  <= sq_r[tc1] + QW'(prod_r[31:0]);
          cnt_r[item_r.cls] <= cnt_r[item_r.cls] + 1'b1;
        end
        gnb_pkg::S_F_START: begin
          if (n_cur == '0) begin
            mean_r[idx_r] <= '0;
            dev_r[idx_r]  <= '0;
            err_r         <= 1'b1;
          end
        end
        gnb_pkg::S_F_MW: if (mdu_sts.done) mean_r[idx_r] <= mdu_res[15:0];
        gnb_pkg::S_F_DEV: begin
          if (mdu_sts.done) begin
            dev_r[idx_r] <= mdu_res[15:0];
            if (mdu_res[15:0] == 16'd0) err_r <= 1'b1;
          end
        end
        gnb_pkg::S_F_NEXT: if (idx_r == 2'd3) stats_valid_r <= !err_r;
        default: stats_valid_r <= stats_valid_r;
      endcase
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    unique case (state_r)
      gnb_pkg::S_IDLE: begin
        item_r <= q_item;
        idx_r  <= '0;
        asum_r <= '0;
        rk_r   <= (q_item.op == gnb_pkg::OP_CLASS) ? gnb_pkg::KIND_CLASS : gnb_pkg::KIND_FINAL;
        rp_r   <= gnb_pkg::PRED_TIE;
        re_r   <= 1'b1;
      end
      gnb_pkg::S_T_MH: prod_r <= 64'(hh);
      gnb_pkg::S_T_AH: prod_r <= 64'(ww);
      gnb_pkg::S_F_S2: if (mdu_sts.done) tmp_r <= '0;
      gnb_pkg::S_F_VAR: if (mdu_sts.done) tmp_r <= mdu_res;
      gnb_pkg::S_F_NEXT: begin
        idx_r <= idx_r + 1'b1;
        rp_r  <= gnb_pkg::PRED_TIE;
        re_r  <= err_r;
      end
      gnb_pkg::S_C_START: prod_r <= 64'(dd);
      gnb_pkg::S_C_Z2: begin
        if (mdu_sts.done) begin
          asum_r <= asum_r + mdu_res[48:0];
          if (!idx_r[0]) idx_r <= idx_r + 1'b1;
        end
      end
      gnb_pkg::S_C_A: prod_r <= 64'(lo_prod);
      gnb_pkg::S_C_B1: begin
        b_r    <= 50'(prod_r[60:30]);
        prod_r <= 64'(hi_prod);
      end
      gnb_pkg::S_C_B2: b_r <= b_r + 50'(prod_r[48:0]);
      gnb_pkg::S_C_E0: begin
        m_one_r <= 1'b1;
        bit_r   <= 4'd15;
      end
      gnb_pkg::S_C_ER: if (mdu_sts.done) root_r <= mdu_res[31:0];
      gnb_pkg::S_C_EM: begin
        if (frac[bit_r]) begin
          m_r     <= m_one_r ? root_r : em_hi;
          m_one_r <= 1'b0;
        end
        bit_r <= bit_r - 1'b1;
      end
      gnb_pkg::S_C_X: begin
        mant_r[cc] <= m_one_r ? 17'h10000 : {1'b0, m_r[31:16]};
        k_r[cc]    <= b_r[49:16];
        prod_r     <= 64'(dev_x);
      end
      gnb_pkg::S_C_XW: begin
        if (mdu_sts.done) begin
          x_r[cc] <= mdu_res;
          idx_r   <= 2'd2;
          asum_r  <= '0;
        end
      end
      gnb_pkg::S_C_CMP: begin
        re_r <= 1'b0;
        if (cmp_gl[1])      rp_r <= gnb_pkg::PRED_ONE;
        else if (cmp_gl[0]) rp_r <= gnb_pkg::PRED_TWO;
        else                rp_r <= gnb_pkg::PRED_TIE;
      end
      default: idx_r <= idx_r;
    endcase
  end

  // Output register: load on emit, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == gnb_pkg::S_EMIT && can_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == gnb_pkg::S_EMIT && can_emit) begin
      out_kind_r <= rk_r;
      out_pred_r <= rp_r;
      out_err_r  <= re_r;
    end
  end

  assign mdu_req             = '{go: go_r, op: op_r};
  assign mdu_a               = ma_r;
  assign mdu_b               = mb_r;
  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_predicted_class = out_pred_r;
  assign out_error           = out_err_r;

  `GNB_ASSERT(a_done_in_wait, mdu_sts.done |-> (state_r == gnb_pkg::S_F_SSQ ||
    state_r == gnb_pkg::S_F_S2 || state_r == gnb_pkg::S_F_VAR || state_r == gnb_pkg::S_F_MW ||
    state_r == gnb_pkg::S_F_DEV || state_r == gnb_pkg::S_C_Z2 || state_r == gnb_pkg::S_C_ER ||
    state_r == gnb_pkg::S_C_XW))
  `GNB_ASSERT(a_valid_dev, (stats_valid_r && state_r == gnb_pkg::S_IDLE) |->
    (dev_r[0] != 16'd0 && dev_r[1] != 16'd0 && dev_r[2] != 16'd0 && dev_r[3] != 16'd0))
  `GNB_ASSERT(a_count_max, (cnt_r[0] <= MAX_CNT) && (cnt_r[1] <= MAX_CNT))
  `GNB_ASSERT(a_idle_unit, (state_r == gnb_pkg::S_IDLE) |-> !mdu_sts.busy)

endmodule

// ===== hw/rtl/gaussian_naive_bayes_two_class_top.sv =====
// Two-class Gaussian naive Bayes classifier over height and weight (Q8.8).
// Train updates the statistics and gives no result. Finalize and classify both run
// on the shared multiply/divide/root unit, which yields one quotient or product bit
// (root: one bit pair) per cycle.
// Input and result sides are parted by a 2-entry queue and an output register.
// Reset is synchronous, active low, and clears all statistics at once.
module gaussian_naive_bayes_two_class_top #(
  parameter int MAX_SAMPLES = 1024,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_class_label,
  input  logic [15:0] in_height,
  input  logic [15:0] in_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [1:0]  out_predicted_class,
  output logic        out_error
);

  localparam int IW = $bits(gnb_pkg::item_t);

  logic                   q_full, q_empty, q_push, q_pop;
  gnb_pkg::item_t         push_item;
  logic [IW-1:0]          pop_bits;
  gnb_pkg::mdu_req_t      mdu_req;
  gnb_pkg::mdu_sts_t      mdu_sts;
  logic [gnb_pkg::DW-1:0] mdu_a, mdu_b, mdu_res;

  gnb_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_class_label (in_class_label),
    .in_height      (in_height),
    .in_weight      (in_weight),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  gnb_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_item),
    .pop   (q_pop),
    .dout  (pop_bits),
    .full  (q_full),
    .empty (q_empty)
  );

  gnb_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_item              (gnb_pkg::item_t'(pop_bits)),
    .q_valid             (!q_empty),
    .q_pop               (q_pop),
    .mdu_req             (mdu_req),
    .mdu_a               (mdu_a),
    .mdu_b               (mdu_b),
    .mdu_sts             (mdu_sts),
    .mdu_res             (mdu_res),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_predicted_class (out_predicted_class),
    .out_error           (out_error)
  );

  gnb_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_a),
    .opb   (mdu_b),
    .sts   (mdu_sts),
    .res   (mdu_res)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the two-class Gaussian naive Bayes classifier.
// Depends on gnb_pkg and gaussian_naive_bayes_two_class_top; a built-in fixed-point predictor
// checks every finalize and classify transaction that carries no typed expectation.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [1:0] LBL_ZERO    = 2'd0;
  localparam logic [1:0] LBL_THREE   = 2'd3;
  localparam logic       K_FIN       = gnb_pkg::KIND_FINAL;
  localparam logic       K_CLS       = gnb_pkg::KIND_CLASS;
  localparam logic [1:0] P_TIE       = gnb_pkg::PRED_TIE;
  localparam int         SAMPLE_CAP  = 1024;
  localparam int         ROWS        = 21;

  typedef struct {
    logic       kind;
    logic [1:0] pred;
    logic       err;
  } verdict_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  lbl;
    logic [15:0] h;
    logic [15:0] w;
    bit          typed;
    logic        kind;
    logic [1:0]  pred;
    logic        err;
  } row_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_command, in_class_label;
  logic [15:0] in_height, in_weight;
  logic        out_valid, out_stall;
  logic        out_result_kind;
  logic [1:0]  out_predicted_class;
  logic        out_error;

  // classifier statistics as the predictor sees them
  logic [63:0] train_count [2];
  logic [63:0] sum_acc [4];
  logic [63:0] sq_acc [4];
  logic [63:0] mean_q [4];
  logic [63:0] dev_q [4];
  bit          stats_ok;

  verdict_t pending_verdicts[$];
  bit       failed;
  int       items_sent;
  int       burst_left;

  gaussian_naive_bayes_two_class_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_class_label(in_class_label),
    .in_height(in_height), .in_weight(in_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_predicted_class(out_predicted_class),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^-(f/65536) in Q1.16, built from repeated square roots of one half
  function automatic logic [63:0] pow2_neg_frac(input logic [15:0] f);
    logic [63:0] root, m;
    root = 64'd1 << 31;
    m = 64'd1 << 32;
    for (int j = 15; j >= 0; j--) begin
      root = isqrt_u64(root << 32);
      if (f[j]) m = (m * root) >> 32;
    end
    return m >> 16;
  endfunction

  function automatic logic [63:0] z_squared(input logic [63:0] x, u, s);
    logic [63:0] d, ss;
    d = x > u ? x - u : u - x;
    ss = s * s;
    if (ss == 0) ss = 1;
    return ((d * d) << 16) / ss;
  endfunction

  // sign of a * 2^d - b
  function automatic int sign_shifted(input logic [63:0] a, b, d);
    logic [63:0] q, rem;
    q = d >= 64 ? 64'd0 : b >> d;
    rem = d >= 64 ? b : b - (q << d);
    if (a > q) return 1;
    if (a < q) return -1;
    return rem != 0 ? -1 : 0;
  endfunction

  function automatic void density(input int c, input logic [63:0] h, w,
                                  output logic [63:0] mant, output logic [63:0] k);
    logic [63:0] a, hi, lo, b;
    a = (z_squared(h, mean_q[c*2], dev_q[c*2]) +
         z_squared(w, mean_q[c*2+1], dev_q[c*2+1])) >> 1;
    hi = a >> 30;
    lo = a & ((64'd1 << 30) - 1);
    b = hi * 64'(gnb_pkg::LOG2E_Q30) + ((lo * 64'(gnb_pkg::LOG2E_Q30)) >> 30);
    k = b >> 16;
    mant = pow2_neg_frac(b[15:0]);
  endfunction

  // advance the statistics by one transaction; return 1 when a result is due
  function automatic bit classifier_step(input logic [1:0] cmd, lbl,
                                         input logic [15:0] h, w, output verdict_t v);
    int c, i, sgn;
    logic [63:0] n, s, s2, sq, var_q, m1, k1, m2, k2, x1, x2;
    bit err;
    v = '{kind: K_FIN, pred: P_TIE, err: 1'b0};
    case (cmd)
      gnb_pkg::CMD_TRAIN: begin
        if (lbl == gnb_pkg::LBL_ONE || lbl == gnb_pkg::LBL_TWO) begin
          c = (lbl == gnb_pkg::LBL_ONE) ? 0 : 1;
          if (train_count[c] < SAMPLE_CAP) begin
            train_count[c]++;
            sum_acc[c*2] += h;
            sum_acc[c*2+1] += w;
            sq_acc[c*2] += 64'(h) * 64'(h);
            sq_acc[c*2+1] += 64'(w) * 64'(w);
          end
        end
        return 1'b0;
      end
      gnb_pkg::CMD_FINAL: begin
        err = 1'b0;
        for (c = 0; c < 2; c++) begin
          n = train_count[c];
          if (n == 0) err = 1'b1;
          for (int f = 0; f < 2; f++) begin
            i = c * 2 + f;
            mean_q[i] = 0;
            dev_q[i] = 0;
            if (n != 0) begin
              s = sum_acc[i];
              s2 = (s * s) / n;
              sq = sq_acc[i];
              var_q = sq > s2 ? (sq - s2) / n : 64'd0;
              mean_q[i] = (s / n) & 64'hFFFF;
              dev_q[i] = isqrt_u64(var_q) & 64'hFFFF;
            end
            if (dev_q[i] == 0) err = 1'b1;
          end
        end
        stats_ok = !err;
        v.err = err;
        return 1'b1;
      end
      gnb_pkg::CMD_CLASS: begin
        v.kind = K_CLS;
        if (!stats_ok) begin
          v.err = 1'b1;
          return 1'b1;
        end
        density(0, h, w, m1, k1);
        density(1, h, w, m2, k2);
        x1 = m1 * (dev_q[2] * dev_q[3]);
        x2 = m2 * (dev_q[0] * dev_q[1]);
        if (k1 <= k2) sgn = sign_shifted(x1, x2, k2 - k1);
        else sgn = -sign_shifted(x2, x1, k1 - k2);
        v.pred = sgn > 0 ? gnb_pkg::PRED_ONE : (sgn < 0 ? gnb_pkg::PRED_TWO : P_TIE);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offer one transaction, wait for acceptance, then queue its expected result
  task automatic offer(input logic [1:0] cmd, lbl, input logic [15:0] h, w,
                       input bit typed, input verdict_t typed_v);
    verdict_t v;
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_command = cmd;
    in_class_label = lbl;
    in_height = h;
    in_weight = w;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (classifier_step(cmd, lbl, h, w, v)) pending_verdicts.push_back(typed ? typed_v : v);
    // burst bookkeeping: drop valid for a random gap when a burst ends
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 15);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic [15:0] near(input logic [15:0] centre);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return centre + 16'($urandom_range(0, 16'h1800)) - 16'h0C00;
  endfunction

  task automatic random_item();
    logic [1:0] lbl;
    int pick;
    verdict_t none;
    none = '{kind: K_FIN, pred: P_TIE, err: 1'b0};
    pick = $urandom_range(0, 99);
    lbl = $urandom_range(0, 9) == 0 ? 2'($urandom) :
          ($urandom_range(0, 1) ? gnb_pkg::LBL_ONE : gnb_pkg::LBL_TWO);
    if (pick < 6)
      offer(gnb_pkg::CMD_FINAL, 2'($urandom), 16'($urandom), 16'($urandom), 1'b0, none);
    else if (pick < 20)
      offer(gnb_pkg::CMD_CLASS, 2'($urandom), near(16'h4800), near(16'h4800), 1'b0, none);
    else if (pick < 22)
      offer(CMD_IGNORED, 2'($urandom), 16'($urandom), 16'($urandom), 1'b0, none);
    else if (lbl == gnb_pkg::LBL_ONE)
      offer(gnb_pkg::CMD_TRAIN, lbl, near(16'h4000), near(16'h3000), 1'b0, none);
    else
      offer(gnb_pkg::CMD_TRAIN, lbl, near(16'h5000), near(16'h6000), 1'b0, none);
  endtask

  // directed rows; typed expectations only where they are obvious
  row_t directed [ROWS] = '{
    '{gnb_pkg::CMD_CLASS, LBL_ZERO,  16'h0000, 16'h0000, 1, K_CLS, P_TIE, 1'b1},
    '{gnb_pkg::CMD_FINAL, LBL_ZERO,  16'h0000, 16'h0000, 1, K_FIN, P_TIE, 1'b1},
    '{CMD_IGNORED,        gnb_pkg::LBL_ONE, 16'hFFFF, 16'hFFFF, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, LBL_ZERO,  16'h1234, 16'h4321, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, LBL_THREE, 16'hFFFF, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_ONE, 16'd1000, 16'd1000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_TWO, 16'd5000, 16'd5000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_FINAL, LBL_ZERO,  16'h0000, 16'h0000, 1, K_FIN, P_TIE, 1'b1},
    '{gnb_pkg::CMD_CLASS, LBL_ZERO,  16'd2000, 16'd2000, 1, K_CLS, P_TIE, 1'b1},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_ONE, 16'd3000, 16'd3000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_TWO, 16'd7000, 16'd7000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_FINAL, LBL_ZERO,  16'h0000, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, LBL_ZERO,  16'd4000, 16'd4000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, gnb_pkg::LBL_ONE, 16'h0000, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, gnb_pkg::LBL_TWO, 16'hFFFF, 16'hFFFF, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, LBL_THREE, 16'd2000, 16'd6000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_ONE, 16'h0000, 16'hFFFF, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_TWO, 16'hFFFF, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_FINAL, LBL_ZERO,  16'h0000, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, LBL_ZERO,  16'hFFFF, 16'h0000, 0, K_FIN, P_TIE, 1'b0},
    '{gnb_pkg::CMD_CLASS, LBL_ZERO,  16'h0000, 16'hFFFF, 0, K_FIN, P_TIE, 1'b0}
  };

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result kind=%0d pred=%0d err=%0d", $time,
                 out_result_kind, out_predicted_class, out_error);
        failed = 1'b1;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                   out_result_kind);
          failed = 1'b1;
        end
        if (out_predicted_class !== want.pred) begin
          $display("%0t: predicted_class expected %0d actual %0d", $time, want.pred,
                   out_predicted_class);
          failed = 1'b1;
        end
        if (out_error !== want.err) begin
          $display("%0t: error expected %0d actual %0d", $time, want.err, out_error);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver: one long hold-off early on, otherwise shifting stall patterns
  initial begin
    bit held;
    int mode;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        if (!held && items_sent >= 40) begin
          held = 1'b1;
          out_stall = 1'b1;
          repeat (4000) @(negedge clk);
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = $urandom_range(0, 9) < 3;
          2: out_stall = $urandom_range(0, 9) < 8;
          default: out_stall = $urandom_range(0, 1);
        endcase
      end
    end
  end

  initial begin
    verdict_t tv;
    in_valid = 1'b0;
    in_command = gnb_pkg::CMD_TRAIN;
    in_class_label = LBL_ZERO;
    in_height = 16'd0;
    in_weight = 16'd0;
    failed = 1'b0;
    items_sent = 0;
    burst_left = 0;
    for (int c = 0; c < 2; c++) train_count[c] = 0;
    for (int i = 0; i < 4; i++) begin
      sum_acc[i] = 0;
      sq_acc[i] = 0;
      mean_q[i] = 0;
      dev_q[i] = 0;
    end
    stats_ok = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed[r]) begin
      tv = '{kind: directed[r].kind, pred: directed[r].pred, err: directed[r].err};
      offer(directed[r].cmd, directed[r].lbl, directed[r].h, directed[r].w,
            directed[r].typed, tv);
    end

    // random mix
    repeat (440) random_item();

    // add fresh samples to both classes, then use the statistics
    tv = '{kind: K_FIN, pred: P_TIE, err: 1'b0};
    repeat (20) offer(gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_ONE, near(16'h4000), near(16'h3000),
                      1'b0, tv);
    repeat (20) offer(gnb_pkg::CMD_TRAIN, gnb_pkg::LBL_TWO, near(16'h5000), near(16'h6000),
                      1'b0, tv);
    offer(gnb_pkg::CMD_FINAL, LBL_ZERO, 16'h0000, 16'h0000, 1'b0, tv);
    repeat (6) offer(gnb_pkg::CMD_CLASS, LBL_ZERO, near(16'h4800), near(16'h4800), 1'b0, tv);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
